@@ src/qph_pkg.sv @@
// ============================================================================
// Quadratic probe hash table: shared package
// Operation, slot state and result codes, port widths and the command and
// status bundles that pass between the controller and the datapath.
// ============================================================================
package qph_pkg;

  // Field widths of the stream payloads
  localparam int unsigned OP_W      = 2;
  localparam int unsigned KEY_W     = 31;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned S_TDATA_W = 40;  // 33 bits of fields, padded to bytes
  localparam int unsigned M_TDATA_W = 16;  // 12 bits of fields, padded to bytes

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Per-slot state
  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_USED    = 2'd1,
    SLOT_DELETED = 2'd2
  } slot_st_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    RES_OK   = 2'd0,
    RES_MISS = 2'd1,
    RES_FULL = 2'd2
  } res_t;

  // Source of the probe count in a result
  typedef enum logic [1:0] {
    CNT_ZERO  = 2'd0,
    CNT_PROBE = 2'd1,
    CNT_BOUND = 2'd2
  } cnt_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     clear_step;  // write one slot state to empty in the clearing pass
    logic     load;        // capture the accepted item and start the walk
    logic     red_step;    // one step of key mod table size (quotient, remainder)
    logic     probe_step;  // advance to the next slot on the probe path
    logic     wr_used;     // store key, mark slot occupied
    logic     wr_del;      // mark slot deleted
    logic     fin;         // latch the result
    res_t     fin_status;
    logic     fin_slot;    // result slot is the current slot, else zero
    cnt_sel_t fin_cnt;
    logic     emit;        // move the result into the output register
  } qph_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;  // last slot of the clearing pass
    op_t  op;          // operation of the item in hand
    logic tbl_full;    // no empty slot left
    logic red_done;    // this reduction step is the last one
    logic st_empty;    // slot read is empty
    logic st_used;     // slot read is occupied
    logic key_hit;     // stored key matches
    logic last_probe;  // current probe is the final one allowed
    logic out_busy;    // output register holds an item not yet taken
  } qph_stat_t;

endpackage

@@ src/qph_ram.sv @@
// ============================================================================
// Quadratic probe hash table: generic RAM
// One write port, one read port, registered read data.
// ============================================================================
module qph_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/qph_dp.sv @@
// ============================================================================
// Quadratic probe hash table: datapath
// Slot state and key memories, key reduction, probe address walk, empty
// slot count, result and output registers.
// ============================================================================
module qph_dp #(
  parameter int unsigned TABLE_SIZE = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  qph_pkg::qph_cmd_t              cmd,
  output qph_pkg::qph_stat_t             stat,
  input  logic [qph_pkg::S_TDATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [qph_pkg::M_TDATA_W-1:0]  m_tdata
);

  import qph_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_SIZE);
  localparam int unsigned CW = $clog2(TABLE_SIZE + 2);
  localparam int unsigned EW = $clog2(TABLE_SIZE + 1);
  localparam logic [IW:0]   N_EXT = (IW + 1)'(TABLE_SIZE);
  localparam logic [IW-1:0] D0    = IW'(9 % TABLE_SIZE);
  localparam logic [IW-1:0] DSTEP = IW'(10 % TABLE_SIZE);
  // ceil(2^RSH / TABLE_SIZE): the shifted product is the exact quotient of any key
  localparam int unsigned   RSH   = KEY_W + IW;
  localparam logic [31:0]   RECIP =
    32'(((64'd1 << RSH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));

  // (a + b) mod table size for a, b already below it
  function automatic logic [IW-1:0] add_mod(input logic [IW-1:0] a, input logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= N_EXT) begin
      s = s - N_EXT;
    end
    return s[IW-1:0];
  endfunction

  op_t           op_r;
  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] quo;
  logic          red_ph;
  logic [IW-1:0] pos;
  logic [IW-1:0] dlt;
  logic [CW-1:0] cnt;
  logic [EW-1:0] empty_cnt;
  logic [IW-1:0] clr_addr;
  res_t          res_status;
  logic [IW-1:0] res_slot;
  logic [CW-1:0] res_count;

  logic [62:0]      red_prod;
  logic [KEY_W-1:0] red_rem;

  logic             st_we;
  logic [IW-1:0]    st_waddr;
  slot_st_t         st_wdata;
  logic [1:0]       st_rdata;
  logic [KEY_W-1:0] key_rdata;

  // Key mod table size: quotient by reciprocal multiply, then remainder
  always_comb begin
    red_prod = 63'(key_r) * 63'(RECIP);
    red_rem  = key_r - quo * KEY_W'(TABLE_SIZE);
  end

  // Memory write selection
  always_comb begin
    st_we    = cmd.clear_step | cmd.wr_used | cmd.wr_del;
    st_waddr = cmd.clear_step ? clr_addr : pos;
    priority if (cmd.clear_step) begin
      st_wdata = SLOT_EMPTY;
    end else if (cmd.wr_used) begin
      st_wdata = SLOT_USED;
    end else begin
      st_wdata = SLOT_DELETED;
    end
  end

  qph_ram #(.WIDTH(2), .DEPTH(TABLE_SIZE)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (pos),
    .rdata (st_rdata)
  );

  qph_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_SIZE)) u_key_ram (
    .clk   (clk),
    .we    (cmd.wr_used),
    .waddr (pos),
    .wdata (key_r),
    .raddr (pos),
    .rdata (key_rdata)
  );

  // Item capture, reduction and probe walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op_t'(s_tdata[OP_W-1:0]);
      key_r   <= s_tdata[OP_W +: KEY_W];
      red_ph  <= 1'b0;
      pos     <= '0;
      dlt     <= D0;
      cnt     <= '0;
    end else if (cmd.red_step) begin
      if (red_ph) begin
        pos <= red_rem[IW-1:0];
      end else begin
        quo <= KEY_W'(red_prod >> RSH);
      end
      red_ph <= 1'b1;
    end else if (cmd.probe_step) begin
      pos <= add_mod(pos, dlt);
      dlt <= add_mod(dlt, DSTEP);
      cnt <= cnt + CW'(1);
    end
  end

  // Clearing pass address and empty slot count
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      empty_cnt <= EW'(TABLE_SIZE);
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + IW'(1);
      end
      if (cmd.wr_used && (st_rdata == SLOT_EMPTY)) begin
        empty_cnt <= empty_cnt - EW'(1);
      end
    end
  end

  // Result latch
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      res_status <= cmd.fin_status;
      res_slot   <= cmd.fin_slot ? pos : '0;
      unique case (cmd.fin_cnt)
        CNT_PROBE: res_count <= cnt + CW'(1);
        CNT_BOUND: res_count <= CW'(TABLE_SIZE + 1);
        default:   res_count <= '0;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {4'b0000, (empty_cnt == '0), COUNT_W'(res_count), SLOT_W'(res_slot),
                  res_status};
    end
  end

  // Status to the controller
  always_comb begin
    stat.clear_last = (clr_addr == IW'(TABLE_SIZE - 1));
    stat.op         = op_r;
    stat.tbl_full   = (empty_cnt == '0);
    stat.red_done   = red_ph;
    stat.st_empty   = (st_rdata == SLOT_EMPTY);
    stat.st_used    = (st_rdata == SLOT_USED);
    stat.key_hit    = (key_rdata == key_r);
    stat.last_probe = (cnt == CW'(TABLE_SIZE - 1));
    stat.out_busy   = m_tvalid & ~m_tready;
  end

endmodule

@@ src/qph_ctrl.sv @@
// ============================================================================
// Quadratic probe hash table: controller
// Sequences the clearing pass, key reduction, probe reads and decisions,
// and hands each result to the output register.
// ============================================================================
module qph_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  qph_pkg::qph_stat_t stat,
  output qph_pkg::qph_cmd_t  cmd
);

  import qph_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_REDUCE = 6'b000100,
    ST_RD     = 6'b001000,
    ST_CHK    = 6'b010000,
    ST_RESP   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        // unused code, or insert with no empty slot: answer at once
        if (stat.op == OP_NONE) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = RES_OK;
          state_next     = ST_RESP;
        end else if ((stat.op == OP_INSERT) && stat.tbl_full) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = RES_FULL;
          state_next     = ST_RESP;
        end else begin
          cmd.red_step = 1'b1;
          if (stat.red_done) begin
            state_next = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_next = ST_CHK;
      end
      ST_CHK: begin
        if (stat.op == OP_INSERT) begin
          priority if (!stat.st_used) begin
            cmd.wr_used    = 1'b1;
            cmd.fin        = 1'b1;
            cmd.fin_status = RES_OK;
            cmd.fin_slot   = 1'b1;
            state_next     = ST_RESP;
          end else if (stat.last_probe) begin
            cmd.fin        = 1'b1;
            cmd.fin_status = RES_FULL;
            state_next     = ST_RESP;
          end else begin
            cmd.probe_step = 1'b1;
            state_next     = ST_RD;
          end
        end else begin
          priority if (stat.st_empty) begin
            cmd.fin        = 1'b1;
            cmd.fin_status = RES_MISS;
            cmd.fin_cnt    = CNT_PROBE;
            state_next     = ST_RESP;
          end else if (stat.st_used && stat.key_hit) begin
            cmd.wr_del     = (stat.op == OP_DELETE);
            cmd.fin        = 1'b1;
            cmd.fin_status = RES_OK;
            cmd.fin_slot   = 1'b1;
            cmd.fin_cnt    = CNT_PROBE;
            state_next     = ST_RESP;
          end else if (stat.last_probe) begin
            cmd.fin        = 1'b1;
            cmd.fin_status = RES_FULL;
            cmd.fin_cnt    = CNT_BOUND;
            state_next     = ST_RESP;
          end else begin
            cmd.probe_step = 1'b1;
            state_next     = ST_RD;
          end
        end
      end
      ST_RESP: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

@@ src/quadratic_probe_hash_table_unit.sv @@
// ============================================================================
// Quadratic probe hash table unit
// Open-addressing table of 31-bit keys, probe path key + 4i + 5i^2.
// ============================================================================
// Usage:
//   The s_ channel takes one operation item (insert, search, delete); the m_
//   channel returns exactly one result item for each, in order.
//   After reset a clearing pass writes every slot state to empty, one slot a
//   cycle; s_tready stays low throughout.
//   An item first reduces its key modulo TABLE_SIZE by a reciprocal multiply
//   (quotient, then remainder), then walks the probe path through the slot
//   memories, each probe a registered read and then a decision.
//   An item makes from 1 to TABLE_SIZE probes; the unused code and insert
//   into a full table make none and are answered from the reduction state.
//   One item is in work at a time: the next is taken the cycle after the
//   result is loaded into the output register.
//   The output register keeps a result until taken; a new item can be
//   accepted meanwhile, and its own result waits in the unit while m_tready
//   stays low.
// ============================================================================
module quadratic_probe_hash_table_unit #(
  parameter int unsigned TABLE_SIZE = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [1:0] operation, [32:2] key, [39:33] zero
  input  logic [qph_pkg::S_TDATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [1:0] status, [5:2] slot, [10:6] probe_count, [11] now_full, [15:12] zero
  output logic [qph_pkg::M_TDATA_W-1:0]  m_tdata
);

  import qph_pkg::*;

  qph_cmd_t  cmd;
  qph_stat_t stat;

  qph_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  qph_dp #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

@@ src/qph_checker.sv @@
// ============================================================================
// Quadratic probe hash table: port checker
// Assertions on the stream ports of the top level, bound to it.
// ============================================================================
module qph_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [qph_pkg::S_TDATA_W-1:0]  s_tdata,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [qph_pkg::M_TDATA_W-1:0]  m_tdata
);

  import qph_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // clearing pass follows reset: no item taken straight after
  a_clear: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("item taken during clearing pass");

  // failed lookups and full tables report slot zero
  a_slot0: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != RES_OK) |-> m_tdata[5:2] == 4'd0)
    else $error("nonzero slot with failure status");

  // a miss always counts at least one probe
  a_miss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == RES_MISS) |-> m_tdata[10:6] != 5'd0)
    else $error("miss with zero probe count");

  // no result appears the cycle after an item is taken
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result too early");

endmodule

bind quadratic_probe_hash_table_unit qph_checker u_qph_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Quadratic probe hash table unit: testbench
// Sends insert, search and delete items over the input stream. A behavioural
// copy of the table predicts each result, and every result item is checked
// field by field. Idle patterns on both sides change between phases. Directed
// items cover the edge cases, random traffic covers the bulk, a long output
// stall fills the unit, and the run ends by filling the table completely.
// ============================================================================
module tb_top;
  import qph_pkg::*;

  localparam int unsigned TBL_SIZE    = 16;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned FREE_RESERVE = 4;  // empty slots kept back in random traffic

  // Expected result of one operation
  typedef struct packed {
    res_t       status;
    logic [3:0] slot;
    logic [4:0] probes;
    logic       now_full;
  } hash_res_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  // Predictor state: mirror of the slot memories
  slot_st_t    tbl_state [TBL_SIZE];
  logic [30:0] tbl_key [TBL_SIZE];
  int unsigned free_slots;

  hash_res_t   pending [$];   // results still owed by the unit, oldest first
  logic [30:0] seen_keys [$]; // keys inserted so far, for hits and re-inserts

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_ok = 0;
  int unsigned n_miss = 0;
  int unsigned n_full = 0;
  int unsigned n_bound = 0;

  quadratic_probe_hash_table_unit #(
    .TABLE_SIZE(TBL_SIZE)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Slot visited by probe i of a key
  function automatic int unsigned probe_slot(logic [30:0] key, int unsigned i);
    longint unsigned v;
    v = longint'(key) + longint'(4 * i) + longint'(5 * i * i);
    return int'(v % TBL_SIZE);
  endfunction

  // Apply one operation to the mirror and return the result it gives
  function automatic hash_res_t apply_op(op_t op, logic [30:0] key);
    hash_res_t   r;
    int unsigned s;
    int unsigned i;
    bit          done;
    r.status = RES_OK;
    r.slot   = '0;
    r.probes = '0;
    done     = 1'b0;
    case (op)
      OP_INSERT: begin
        // rejected outright once no empty slot is left, tombstones or not
        r.status = RES_FULL;
        if (free_slots != 0) begin
          for (i = 0; i < TBL_SIZE && !done; i++) begin
            s = probe_slot(key, i);
            if (tbl_state[s] != SLOT_USED) begin
              if (tbl_state[s] == SLOT_EMPTY) free_slots--;
              tbl_state[s] = SLOT_USED;
              tbl_key[s]   = key;
              r.slot       = 4'(s);
              r.status     = RES_OK;
              done         = 1'b1;
            end
          end
        end
      end
      OP_SEARCH, OP_DELETE: begin
        // tombstones are passed over; the walk stops at an empty slot or the key
        r.status = RES_FULL;
        r.probes = 5'(TBL_SIZE + 1);
        for (i = 0; i < TBL_SIZE && !done; i++) begin
          s = probe_slot(key, i);
          if (tbl_state[s] == SLOT_EMPTY) begin
            r.status = RES_MISS;
            r.probes = 5'(i + 1);
            done     = 1'b1;
          end else if (tbl_state[s] == SLOT_USED && tbl_key[s] == key) begin
            r.status = RES_OK;
            r.slot   = 4'(s);
            r.probes = 5'(i + 1);
            done     = 1'b1;
          end
        end
        if (op == OP_DELETE && r.status == RES_OK) tbl_state[r.slot] = SLOT_DELETED;
      end
      default: ;
    endcase
    if (r.status != RES_OK) r.slot = '0;
    r.now_full = (free_slots == 0);
    return r;
  endfunction

  // Half the fresh keys span all 31 bits, half share a small range to collide
  function automatic logic [30:0] fresh_key();
    if ($urandom_range(1) == 1) return 31'($urandom());
    return 31'($urandom_range(63));
  endfunction

  function automatic logic [30:0] known_key();
    if (seen_keys.size() == 0) return fresh_key();
    return seen_keys[$urandom_range(seen_keys.size() - 1)];
  endfunction

  // Offer one item and wait for it to be taken; valid stays high afterwards
  // so that back-to-back items need no gap
  task automatic send_op(op_t op, logic [30:0] key);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= S_TDATA_W'({$urandom(), $urandom()});
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, key, op};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    pending.push_back(apply_op(op, key));
    n_sent++;
  endtask

  function automatic void cmp_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endfunction

  // Result check, then the receiver's ready for the next cycle
  always @(posedge clk) begin : result_check
    hash_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual %h", $time, m_tdata);
        fail_count++;
      end else begin
        want = pending.pop_front();
        cmp_field("status", want.status, m_tdata[1:0]);
        cmp_field("slot", want.slot, m_tdata[5:2]);
        cmp_field("probe_count", want.probes, m_tdata[10:6]);
        cmp_field("now_full", want.now_full, m_tdata[11]);
        case (want.status)
          RES_OK:   n_ok++;
          RES_MISS: n_miss++;
          default:  n_full++;
        endcase
        if (want.probes == 5'(TBL_SIZE + 1)) n_bound++;
      end
    end
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Edge cases on a fresh table: misses on empty, extreme keys, duplicates,
  // tombstones, the unused code and a path that runs to the probe bound
  task automatic test_directed_cases();
    send_op(OP_SEARCH, 31'd0);
    send_op(OP_DELETE, 31'd0);
    send_op(OP_INSERT, 31'd0);
    send_op(OP_INSERT, 31'h7FFF_FFFF);
    send_op(OP_SEARCH, 31'h7FFF_FFFF);
    send_op(OP_INSERT, 31'd0);          // duplicate goes further down the path
    send_op(OP_SEARCH, 31'd0);
    send_op(OP_DELETE, 31'd0);
    send_op(OP_SEARCH, 31'd0);          // skips the tombstone, finds the copy
    send_op(OP_INSERT, 31'd16);         // reuses the tombstone
    send_op(OP_NONE, 31'h7FFF_FFFF);
    send_op(OP_INSERT, 31'd32);
    send_op(OP_INSERT, 31'd48);         // path of residue 0 is now all occupied
    send_op(OP_INSERT, 31'd64);         // bound reached with empty slots left
    send_op(OP_SEARCH, 31'd80);
    send_op(OP_DELETE, 31'd80);
    send_op(OP_SEARCH, 31'h5555_5555);
    send_op(OP_DELETE, 31'h2AAA_AAAA);
    seen_keys = '{31'd0, 31'h7FFF_FFFF, 31'd16, 31'd32, 31'd48};
  endtask

  // Random traffic: mostly lookups and re-inserts of known keys so that the
  // table stays partly empty, with some fresh keys, noise and unused codes
  task automatic test_mixed_traffic(int unsigned n_items);
    int unsigned roll;
    op_t         op;
    logic [30:0] key;
    bit          live;
    for (int unsigned n = 0; n < n_items; n++) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        op  = op_t'($urandom_range(3));
        key = fresh_key();
        if (op == OP_INSERT && free_slots <= FREE_RESERVE) op = OP_NONE;
      end else if (roll < 40) begin
        op = OP_INSERT;
        if (free_slots > FREE_RESERVE && ($urandom_range(1) == 1 || seen_keys.size() == 0)) begin
          key = fresh_key();
          seen_keys.push_back(key);
          if (seen_keys.size() > 40) void'(seen_keys.pop_front());
        end else begin
          key  = known_key();
          live = 1'b0;
          foreach (tbl_state[s]) begin
            if (tbl_state[s] == SLOT_USED && tbl_key[s] == key) live = 1'b1;
          end
          // a second copy of a live key may eat an empty slot
          if (live && free_slots <= FREE_RESERVE) op = OP_DELETE;
        end
      end else begin
        op  = (roll < 70) ? OP_SEARCH : OP_DELETE;
        key = ($urandom_range(4) != 0) ? known_key() : fresh_key();
      end
      send_op(op, key);
    end
  endtask

  // Long output hold-off while items keep coming, so the input stalls
  task automatic test_output_stall();
    stall_left <= 400;
    for (int n = 0; n < 20; n++) send_op(op_t'($urandom_range(2)), known_key());
  endtask

  // Fill every empty slot, then work on the full table
  task automatic test_full_table();
    logic [30:0] key;
    for (int unsigned s = 0; s < TBL_SIZE; s++) begin
      if (tbl_state[s] == SLOT_EMPTY) begin
        key = {27'($urandom()), 4'(s)};
        seen_keys.push_back(key);
        send_op(OP_INSERT, key);
      end
    end
    send_op(OP_INSERT, fresh_key());
    send_op(OP_SEARCH, fresh_key());
    key = known_key();
    send_op(OP_DELETE, key);
    send_op(OP_INSERT, key);            // tombstones left, still refused
    send_op(OP_SEARCH, key);
    send_op(OP_NONE, 31'd0);
    for (int n = 0; n < 6; n++) send_op(op_t'($urandom_range(2)), known_key());
  endtask

  initial begin
    foreach (tbl_state[s]) begin
      tbl_state[s] = SLOT_EMPTY;
      tbl_key[s]   = '0;
    end
    free_slots = TBL_SIZE;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 29;
    recv_idle_pct = 76;
    test_directed_cases();
    test_mixed_traffic(300);

    send_idle_pct = 76;
    recv_idle_pct = 29;
    test_mixed_traffic(300);
    test_output_stall();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_mixed_traffic(300);
    test_full_table();
    s_tvalid <= 1'b0;

    while (pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("tb_top: %0d items sent, %0d results checked: %0d done/found, %0d missed, %0d full",
             n_sent, n_checked, n_ok, n_miss, n_full);
    $display("tb_top: %0d lookups ran to the probe bound; table ended with %0d empty slots",
             n_bound, free_slots);
    if (fail_count == 0 && pending.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
